[sv/cts_pkg.sv]
package cts_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ONE = 1 << FRAC_BITS;
	localparam int HALF = ONE / 2;
	localparam logic signed [15:0] ONE_S = 16'(ONE);

	localparam int MAG_W = FRAC_BITS + 1;
	localparam int RAD_W = 30;
	localparam int ROOT_W = 15;
	localparam int REM_W = 17;
	localparam int SQRT_DIGITS = 3;
	localparam int SQRT_STAGES = ROOT_W / SQRT_DIGITS;

	localparam int XW = 45;
	localparam int AW = 26;
	localparam int NORM_BIT = 40;
	localparam int TURN_BITS = 24;
	localparam int CORDIC_STEPS = 18;

	localparam logic [15:0] Q15_ONE = 16'd32768;
	localparam logic [15:0] Q15_HALF = 16'd16384;

	localparam logic signed [AW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050, 26'sd166669, 26'sd83416,
		26'sd41718, 26'sd20860, 26'sd10430, 26'sd5215, 26'sd2608, 26'sd1304,
		26'sd652, 26'sd326, 26'sd163, 26'sd81, 26'sd41, 26'sd20
	};

	typedef struct packed {
		logic signed [15:0] cube_x;
		logic signed [15:0] cube_y;
		logic signed [15:0] cube_z;
		logic seam_u_end;
		logic seam_pole;
		logic [15:0] vertex_index;
	} cube_t;

	typedef struct packed {
		logic signed [15:0] sphere_x;
		logic signed [15:0] sphere_y;
		logic signed [15:0] sphere_z;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic [15:0] slot_out;
	} sphere_t;

endpackage

[sv/cube_to_sphere_vertex.sv]
// Maps a cube-surface point (signed Q2.14) onto the unit sphere and derives texture u/v
// (Q1.15). Fully pipelined: one vertex per clock while the output is not stalled. The pipe
// runs through two 5-stage square roots in series (stretch factor, then the
// horizontal radius for v) and two 18-stage CORDICs, one for each angle. The output
// register holds a result until taken; while it is held the whole pipe stalls and the
// input is not ready, so cube_ready follows sphere_ready when a result is waiting.
module cube_to_sphere_vertex (
	input logic clk,
	input logic arst_n,
	input logic cube_valid,
	output logic cube_ready,
	input cts_pkg::cube_t cube,
	output logic sphere_valid,
	input logic sphere_ready,
	output cts_pkg::sphere_t sphere
);
	import cts_pkg::*;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0] neg;
		logic seam_u_end;
		logic seam_pole;
		logic [15:0] slot;
	} side_a_t;

	typedef struct packed {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] sz;
		logic signed [15:0] t;
		logic seam_u_end;
		logic seam_pole;
		logic [15:0] slot;
	} side_b_t;

	typedef struct packed {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] sz;
		logic seam_u_end;
		logic seam_pole;
		logic [15:0] slot;
		logic u_zero;
		logic z_neg;
		logic h_zero;
		logic t_pos;
		logic t_zero;
	} side_c_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [AW-1:0] a;
	} norm_t;

	function automatic norm_t cts_norm(input logic signed [16:0] y, input logic signed [16:0] x);
		norm_t r;
		logic signed [16:0] xr;
		logic signed [16:0] yr;
		logic [16:0] ay;
		logic [16:0] mg;
		logic [5:0] sh;
		r.a = '0;
		xr = x;
		yr = y;
		if (x < 0) begin
			if (y >= 0) begin
				xr = y;
				yr = -x;
				r.a = AW'(1 << (TURN_BITS - 2));
			end else begin
				xr = -y;
				yr = x;
				r.a = -AW'(1 << (TURN_BITS - 2));
			end
		end
		ay = (yr < 0) ? 17'(-yr) : 17'(yr);
		mg = 17'(xr) | ay;
		sh = '0;
		for (int i = 0; i < 17; i++) begin
			if (mg[i]) begin
				sh = 6'(NORM_BIT - i);
			end
		end
		r.x = XW'(xr) <<< sh;
		r.y = XW'(yr) <<< sh;
		return r;
	endfunction

	function automatic logic [15:0] sat_q15(input logic signed [27:0] v);
		if (v < 0) begin
			return '0;
		end else if (v > 28'sd32768) begin
			return Q15_ONE;
		end else begin
			return v[15:0];
		end
	endfunction

	logic en;
	logic vld_q;
	sphere_t res_q;

	assign en = !vld_q || sphere_ready;
	assign cube_ready = en;

	// stage 1: clamp, magnitude
	logic signed [15:0] cin [3];
	side_a_t a_in;
	logic v_s1, v_s2, v_s3, v_s4;
	side_a_t a_s1, a_s2, a_s3, a_s4;

	assign cin[0] = cube.cube_x;
	assign cin[1] = cube.cube_y;
	assign cin[2] = cube.cube_z;

	always_comb begin
		logic signed [15:0] cl;
		logic signed [15:0] ab;
		a_in.seam_u_end = cube.seam_u_end;
		a_in.seam_pole = cube.seam_pole;
		a_in.slot = cube.vertex_index;
		for (int i = 0; i < 3; i++) begin
			if (cin[i] > ONE_S) begin
				cl = ONE_S;
			end else if (cin[i] < -ONE_S) begin
				cl = -ONE_S;
			end else begin
				cl = cin[i];
			end
			ab = (cl < 0) ? -cl : cl;
			a_in.neg[i] = cl < 0;
			a_in.mag[i] = ab[MAG_W-1:0];
		end
	end

	// stages 2-4: squares, stretch factor
	logic [MAG_W-1:0] sq_s2 [3];
	logic [MAG_W-1:0] half_s3 [3];
	logic [MAG_W-1:0] p_s3 [3];
	logic [MAG_W-1:0] f_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_in;
			a_s2 <= a_s1;
			a_s3 <= a_s2;
			a_s4 <= a_s3;
			for (int i = 0; i < 3; i++) begin
				logic [2*MAG_W-1:0] pr;
				pr = a_s1.mag[i] * a_s1.mag[i] + (2*MAG_W)'(HALF);
				sq_s2[i] <= pr[FRAC_BITS +: MAG_W];
			end
			for (int i = 0; i < 3; i++) begin
				logic [2*MAG_W-1:0] pb;
				logic [MAG_W:0] hs;
				pb = sq_s2[(i+1)%3] * sq_s2[(i+2)%3];
				hs = {1'b0, sq_s2[(i+1)%3]} + {1'b0, sq_s2[(i+2)%3]};
				half_s3[i] <= hs[MAG_W:1];
				p_s3[i] <= pb[FRAC_BITS +: MAG_W];
			end
			for (int i = 0; i < 3; i++) begin
				logic [2*MAG_W-1:0] pq;
				logic signed [MAG_W+1:0] fv;
				pq = p_s3[i] * MAG_W'(21846);
				fv = (MAG_W+2)'(ONE) - (MAG_W+2)'(half_s3[i]) + (MAG_W+2)'(pq[2*MAG_W-1:16]);
				if (fv < 0) begin
					f_s4[i] <= '0;
				end else if (fv > (MAG_W+2)'(ONE)) begin
					f_s4[i] <= MAG_W'(ONE);
				end else begin
					f_s4[i] <= fv[MAG_W-1:0];
				end
			end
		end
	end

	// stages 5-9: square root of stretch factor
	logic [ROOT_W-1:0] root_f [3];
	logic [SQRT_STAGES-1:0] vf_s;
	side_a_t af_s [SQRT_STAGES];

	for (genvar l = 0; l < 3; l++) begin : g_fsq
		cts_sqrt u_sqrt (
			.clk (clk),
			.en (en),
			.rad (RAD_W'({f_s4[l], {FRAC_BITS{1'b0}}})),
			.root (root_f[l])
		);
	end

	// stages 10-12: scale, sign, radicand for v
	logic v_s10, v_s11, v_s12;
	side_a_t a_s10;
	logic [2*MAG_W-1:0] prod_s10 [3];
	side_b_t b_s11, b_s12;
	side_b_t b_in;
	logic [RAD_W-1:0] rad_s12;

	always_comb begin
		logic [2*MAG_W-1:0] rr;
		logic signed [15:0] sv [3];
		for (int i = 0; i < 3; i++) begin
			rr = prod_s10[i] + (2*MAG_W)'(HALF);
			sv[i] = a_s10.neg[i] ? -16'({1'b0, rr[FRAC_BITS +: MAG_W]})
				: 16'({1'b0, rr[FRAC_BITS +: MAG_W]});
		end
		b_in.sx = sv[0];
		b_in.sy = sv[1];
		b_in.sz = sv[2];
		b_in.t = -sv[1];
		b_in.seam_u_end = a_s10.seam_u_end;
		b_in.seam_pole = a_s10.seam_pole;
		b_in.slot = a_s10.slot;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [31:0] tt;
			af_s[0] <= a_s4;
			for (int k = 1; k < SQRT_STAGES; k++) begin
				af_s[k] <= af_s[k-1];
			end
			a_s10 <= af_s[SQRT_STAGES-1];
			for (int i = 0; i < 3; i++) begin
				prod_s10[i] <= af_s[SQRT_STAGES-1].mag[i] * root_f[i];
			end
			b_s11 <= b_in;
			tt = b_s11.t * b_s11.t;
			b_s12 <= b_s11;
			rad_s12 <= RAD_W'(ONE * ONE) - tt[RAD_W-1:0];
		end
	end

	// stages 13-17: horizontal radius
	logic [ROOT_W-1:0] root_h;
	logic [SQRT_STAGES-1:0] vb_s;
	side_b_t bq_s [SQRT_STAGES];

	cts_sqrt u_sqrt_h (
		.clk (clk),
		.en (en),
		.rad (rad_s12),
		.root (root_h)
	);

	// stage 18: quadrant fold and normalize
	logic v_s18;
	norm_t nu_s18, nv_s18;
	side_c_t c_s18;
	side_b_t bl;

	assign bl = bq_s[SQRT_STAGES-1];

	always_ff @(posedge clk) begin
		if (en) begin
			bq_s[0] <= b_s12;
			for (int k = 1; k < SQRT_STAGES; k++) begin
				bq_s[k] <= bq_s[k-1];
			end
			nu_s18 <= cts_norm(17'(bl.sx), 17'(bl.sz));
			nv_s18 <= cts_norm(17'(bl.t), 17'({1'b0, root_h}));
			c_s18.sx <= bl.sx;
			c_s18.sy <= bl.sy;
			c_s18.sz <= bl.sz;
			c_s18.seam_u_end <= bl.seam_u_end;
			c_s18.seam_pole <= bl.seam_pole;
			c_s18.slot <= bl.slot;
			c_s18.u_zero <= bl.sx == 0;
			c_s18.z_neg <= bl.sz < 0;
			c_s18.h_zero <= root_h == '0;
			c_s18.t_pos <= bl.t > 0;
			c_s18.t_zero <= bl.t == 0;
		end
	end

	// stages 19-36: angles
	logic signed [AW-1:0] ang_u, ang_v;
	logic [CORDIC_STEPS-1:0] vc_s;
	side_c_t cq_s [CORDIC_STEPS];

	cts_cordic u_cordic_u (
		.clk (clk),
		.en (en),
		.x0 (nu_s18.x),
		.y0 (nu_s18.y),
		.a0 (nu_s18.a),
		.ang (ang_u)
	);

	cts_cordic u_cordic_v (
		.clk (clk),
		.en (en),
		.x0 (nv_s18.x),
		.y0 (nv_s18.y),
		.a0 (nv_s18.a),
		.ang (ang_v)
	);

	// stage 37: texture coordinates, output register
	side_c_t cl_c;
	sphere_t res_in;

	assign cl_c = cq_s[CORDIC_STEPS-1];

	always_comb begin
		logic signed [27:0] ue;
		logic signed [27:0] ve;
		ue = 28'(ang_u);
		if (ang_u < 0) begin
			ue = ue + 28'sd16777216;
		end
		ue = (ue + 28'sd256) >>> 9;
		res_in.tex_u = sat_q15(ue);
		if (cl_c.u_zero) begin
			res_in.tex_u = cl_c.z_neg ? Q15_HALF : '0;
		end
		if (cl_c.seam_u_end) begin
			res_in.tex_u = Q15_ONE;
		end else if (cl_c.seam_pole) begin
			res_in.tex_u = Q15_HALF;
		end
		ve = (28'(ang_v) <<< 1) + 28'sd8388608 + 28'sd256;
		if (cl_c.h_zero) begin
			res_in.tex_v = cl_c.t_pos ? Q15_ONE : '0;
		end else if (cl_c.t_zero) begin
			res_in.tex_v = Q15_HALF;
		end else begin
			res_in.tex_v = sat_q15(ve >>> 9);
		end
		res_in.sphere_x = cl_c.sx;
		res_in.sphere_y = cl_c.sy;
		res_in.sphere_z = cl_c.sz;
		res_in.slot_out = cl_c.slot;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cq_s[0] <= c_s18;
			for (int k = 1; k < CORDIC_STEPS; k++) begin
				cq_s[k] <= cq_s[k-1];
			end
			res_q <= res_in;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			vf_s <= '0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			vb_s <= '0;
			v_s18 <= 1'b0;
			vc_s <= '0;
			vld_q <= 1'b0;
		end else if (en) begin
			v_s1 <= cube_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vf_s <= {vf_s[SQRT_STAGES-2:0], v_s4};
			v_s10 <= vf_s[SQRT_STAGES-1];
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			vb_s <= {vb_s[SQRT_STAGES-2:0], v_s12};
			v_s18 <= vb_s[SQRT_STAGES-1];
			vc_s <= {vc_s[CORDIC_STEPS-2:0], v_s18};
			vld_q <= vc_s[CORDIC_STEPS-1];
		end
	end

	assign sphere_valid = vld_q;
	assign sphere = res_q;

endmodule

[sv/cts_sqrt.sv]
module cts_sqrt (
	input logic clk,
	input logic en,
	input logic [cts_pkg::RAD_W-1:0] rad,
	output logic [cts_pkg::ROOT_W-1:0] root
);
	import cts_pkg::*;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] q;
		logic [RAD_W-1:0] rad;
	} sqs_t;

	sqs_t st_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stg
		sqs_t cur;
		sqs_t nxt;

		if (k == 0) begin : g_first
			assign cur = '{rem: '0, q: '0, rad: rad};
		end else begin : g_next
			assign cur = st_s[k-1];
		end

		always_comb begin
			sqs_t w;
			logic [REM_W+1:0] r2;
			logic [REM_W+1:0] tr;
			w = cur;
			for (int j = 0; j < SQRT_DIGITS; j++) begin
				r2 = {w.rem, w.rad[2*(ROOT_W-1-SQRT_DIGITS*k-j) +: 2]};
				tr = {2'b00, w.q, 2'b01};
				if (r2 >= tr) begin
					r2 = r2 - tr;
					w.q = {w.q[ROOT_W-2:0], 1'b1};
				end else begin
					w.q = {w.q[ROOT_W-2:0], 1'b0};
				end
				w.rem = r2[REM_W-1:0];
			end
			nxt = w;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= nxt;
			end
		end
	end

	assign root = st_s[SQRT_STAGES-1].q;

endmodule

[sv/cts_cordic.sv]
module cts_cordic (
	input logic clk,
	input logic en,
	input logic signed [cts_pkg::XW-1:0] x0,
	input logic signed [cts_pkg::XW-1:0] y0,
	input logic signed [cts_pkg::AW-1:0] a0,
	output logic signed [cts_pkg::AW-1:0] ang
);
	import cts_pkg::*;

	logic signed [XW-1:0] x_s [CORDIC_STEPS-1];
	logic signed [XW-1:0] y_s [CORDIC_STEPS-1];
	logic signed [AW-1:0] a_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stg
		logic signed [XW-1:0] xi;
		logic signed [XW-1:0] yi;
		logic signed [AW-1:0] ai;
		logic signed [AW-1:0] an;

		if (i == 0) begin : g_first
			assign xi = x0;
			assign yi = y0;
			assign ai = a0;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign ai = a_s[i-1];
		end

		assign an = (yi >= 0) ? ai + ATAN_TURNS[i] : ai - ATAN_TURNS[i];

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[i] <= an;
			end
		end

		if (i < CORDIC_STEPS - 1) begin : g_xy
			logic signed [XW-1:0] xn;
			logic signed [XW-1:0] yn;

			always_comb begin
				if (yi >= 0) begin
					xn = xi + (yi >>> i);
					yn = yi - (xi >>> i);
				end else begin
					xn = xi - (yi >>> i);
					yn = yi + (xi >>> i);
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[i] <= xn;
					y_s[i] <= yn;
				end
			end
		end
	end

	assign ang = a_s[CORDIC_STEPS-1];

endmodule

[sv/cts_chk.sv]
module cts_chk (
	input logic clk,
	input logic arst_n,
	input logic cube_valid,
	input logic cube_ready,
	input cts_pkg::cube_t cube,
	input logic sphere_valid,
	input logic sphere_ready,
	input cts_pkg::sphere_t sphere
);
	import cts_pkg::*;

	// a waiting beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sphere_valid && !sphere_ready |=> sphere_valid && $stable(sphere))
		else $error("output beat changed while stalled");

	// pipe moves whenever the output slot is free
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(!sphere_valid || sphere_ready) |-> cube_ready)
		else $error("input stalled with free output");

	a_tex: assert property (@(posedge clk) disable iff (!arst_n)
		sphere_valid |-> sphere.tex_u <= Q15_ONE && sphere.tex_v <= Q15_ONE)
		else $error("texture coordinate out of range");

	a_sph: assert property (@(posedge clk) disable iff (!arst_n)
		sphere_valid |-> sphere.sphere_x <= ONE_S && sphere.sphere_x >= -ONE_S
			&& sphere.sphere_y <= ONE_S && sphere.sphere_y >= -ONE_S
			&& sphere.sphere_z <= ONE_S && sphere.sphere_z >= -ONE_S)
		else $error("sphere coordinate out of range");

endmodule

bind cube_to_sphere_vertex cts_chk u_chk (.*);

[sim/cube_to_sphere_vertex_tb.sv]
module cube_to_sphere_vertex_tb;
	import cts_pkg::*;

	logic clk;
	logic arst_n;
	logic cube_valid;
	logic cube_ready;
	cube_t cube;
	logic sphere_valid;
	logic sphere_ready;
	sphere_t sphere;

	sphere_t vertex_q[$];
	int mismatches;
	int results_seen;
	int out_wait;

	cube_to_sphere_vertex u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cube_valid(cube_valid),
		.cube_ready(cube_ready),
		.cube(cube),
		.sphere_valid(sphere_valid),
		.sphere_ready(sphere_ready),
		.sphere(sphere)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint floor_sqrt(longint n);
		longint r;
		longint b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint abs64(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// vectoring CORDIC, angle in 2^-24 turn
	function automatic longint turn_angle(longint y, longint x);
		longint ang;
		longint t;
		longint xs;
		longint ys;
		ang = 0;
		while (abs64(x) < (64'sd1 << NORM_BIT) && abs64(y) < (64'sd1 << NORM_BIT)) begin
			x = x * 2;
			y = y * 2;
		end
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t;
				ang = 64'sd1 << (TURN_BITS - 2);
			end else begin
				t = x; x = -y; y = t;
				ang = -(64'sd1 << (TURN_BITS - 2));
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; ang = ang + longint'(ATAN_TURNS[i]);
			end else begin
				x = x - ys; y = y + xs; ang = ang - longint'(ATAN_TURNS[i]);
			end
		end
		return ang;
	endfunction

	function automatic longint stretch(longint a, longint sqb, longint sqc);
		longint f;
		longint s;
		longint r;
		f = ONE - (sqb + sqc) / 2 + ((sqb * sqc) >>> FRAC_BITS) / 3;
		if (f < 0) f = 0;
		if (f > ONE) f = ONE;
		s = floor_sqrt(f << FRAC_BITS);
		r = (abs64(a) * s + HALF) >>> FRAC_BITS;
		return (a < 0) ? -r : r;
	endfunction

	function automatic sphere_t map_vertex(cube_t c);
		sphere_t o;
		longint p[3];
		longint sq[3];
		longint sx, sy, sz, u, v, t, h, a;
		p[0] = c.cube_x;
		p[1] = c.cube_y;
		p[2] = c.cube_z;
		for (int i = 0; i < 3; i++) begin
			if (p[i] > ONE) p[i] = ONE;
			if (p[i] < -ONE) p[i] = -ONE;
			sq[i] = (abs64(p[i]) * abs64(p[i]) + HALF) >>> FRAC_BITS;
		end
		sx = stretch(p[0], sq[1], sq[2]);
		sy = stretch(p[1], sq[2], sq[0]);
		sz = stretch(p[2], sq[0], sq[1]);
		if (sx == 0) begin
			u = (sz < 0) ? 16384 : 0;
		end else begin
			a = turn_angle(sx, sz);
			if (a < 0) a = a + (64'sd1 << TURN_BITS);
			u = (a + 256) >>> 9;
			if (u < 0) u = 0;
			if (u > 32768) u = 32768;
		end
		if (c.seam_u_end)
			u = Q15_ONE;
		else if (c.seam_pole)
			u = Q15_HALF;
		t = -sy;
		h = floor_sqrt(longint'(ONE) * ONE - t * t);
		if (h == 0) begin
			v = (t > 0) ? 32768 : 0;
		end else if (t == 0) begin
			v = 16384;
		end else begin
			a = 2 * turn_angle(t, h) + (64'sd1 << (TURN_BITS - 1)) + 256;
			if (a < 0) v = 0;
			else begin
				v = a >>> 9;
				if (v > 32768) v = 32768;
			end
		end
		o.sphere_x = 16'(sx);
		o.sphere_y = 16'(sy);
		o.sphere_z = 16'(sz);
		o.tex_u = 16'(u);
		o.tex_v = 16'(v);
		o.slot_out = c.vertex_index;
		return o;
	endfunction

	// valid stays high across back-to-back beats; it drops only for idle cycles
	task automatic send_vertex(cube_t c);
		int idle;
		idle = $urandom_range(0, 5);
		if (idle != 0) begin
			cube_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		vertex_q.push_back(map_vertex(c));
		cube <= c;
		cube_valid <= 1'b1;
		@(posedge clk);
		while (!cube_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic cube_t make_vertex(int x, int y, int z, bit ue, bit pole, int idx);
		cube_t c;
		c.cube_x = 16'(x);
		c.cube_y = 16'(y);
		c.cube_z = 16'(z);
		c.seam_u_end = ue;
		c.seam_pole = pole;
		c.vertex_index = 16'(idx);
		return c;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	// point on a random face of the cube
	function automatic cube_t face_vertex();
		int q[3];
		int k;
		for (int i = 0; i < 3; i++) q[i] = rand_coord();
		k = $urandom_range(0, 2);
		q[k] = $urandom_range(0, 1) ? ONE : -ONE;
		return make_vertex(q[0], q[1], q[2], $urandom_range(0, 15) == 0,
			$urandom_range(0, 15) == 0, $urandom);
	endfunction

	task automatic test_corners();
		int s[3] = '{-ONE, 0, ONE};
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				send_vertex(make_vertex(s[i], s[j], ONE, 0, 0, i * 3 + j));
		send_vertex(make_vertex(0, 0, -ONE, 0, 0, 16'hffff));
		send_vertex(make_vertex(0, ONE, 0, 0, 0, 0));
		send_vertex(make_vertex(0, -ONE, 0, 0, 0, 1));
		send_vertex(make_vertex(0, 0, 0, 0, 0, 2));
		send_vertex(make_vertex(ONE, 0, 0, 0, 0, 3));
		send_vertex(make_vertex(-ONE, -ONE, -ONE, 0, 0, 4));
	endtask

	task automatic test_clamp();
		send_vertex(make_vertex(32767, -32768, 20000, 0, 0, 5));
		send_vertex(make_vertex(-32768, 32767, -16385, 0, 0, 6));
		send_vertex(make_vertex(16385, 1, -1, 0, 0, 7));
	endtask

	task automatic test_seams();
		send_vertex(make_vertex(ONE, 100, -200, 1, 0, 8));
		send_vertex(make_vertex(-ONE, 100, 200, 0, 1, 9));
		send_vertex(make_vertex(500, ONE, -300, 1, 1, 10));
	endtask

	task automatic test_random(int n);
		cube_t c;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				c = make_vertex($urandom, $urandom, $urandom, 1'($urandom), 1'($urandom),
					$urandom);
			else
				c = face_vertex();
			send_vertex(c);
			if (i == n / 2) begin
				cube_valid <= 1'b0;
				wait (vertex_q.size() == 0);
				@(negedge clk);
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_wait > 0) begin
				sphere_ready <= 1'b0;
				out_wait--;
			end else begin
				sphere_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		sphere_t exp_v;
		if (arst_n && sphere_valid && sphere_ready) begin
			results_seen++;
			out_wait = $urandom_range(0, 5);
			if (vertex_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", sphere);
			end else begin
				exp_v = vertex_q.pop_front();
				if (sphere !== exp_v) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch slot %0d: exp %p got %p", exp_v.slot_out,
							exp_v, sphere);
				end
			end
		end
	end

	initial begin
		#30000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cube_valid = 1'b0;
		cube = '0;
		sphere_ready = 1'b0;
		mismatches = 0;
		results_seen = 0;
		out_wait = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_corners();
		test_clamp();
		test_seams();
		test_random(1650);
		cube_valid <= 1'b0;
		wait (vertex_q.size() == 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && vertex_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[cube_to_sphere_vertex.f]
sv/cts_pkg.sv
sv/cts_sqrt.sv
sv/cts_cordic.sv
sv/cube_to_sphere_vertex.sv
sv/cts_chk.sv
sim/cube_to_sphere_vertex_tb.sv
